>>> src/lvm_pkg.sv
// lvm_pkg: shared types, constants and helpers for the look-at view matrix block.
// No dependencies. Used by every module under src.
package lvm_pkg;

  // Fixed-point format: FRAC_BITS fractional bits
  localparam int FRAC_BITS = 16;
  // Quotient bits of one normalize divide (results stay at or below 1.0)
  localparam int QW = FRAC_BITS + 2;
  localparam int JW = $clog2(QW);
  localparam int IN_W = 288;
  localparam int OUT_W = 128;
  localparam logic signed [31:0] ONE_FIX = 32'sd1 <<< FRAC_BITS;

  // One queued request: eye, up and target minus eye
  typedef struct packed {
    logic [2:0][31:0] eye;
    logic [2:0][31:0] up;
    logic [2:0][32:0] d;
  } item_t;

  // One matrix column on its way out
  typedef struct packed {
    logic [1:0]  column;
    logic [31:0] row0;
    logic [31:0] row1;
    logic [31:0] row2;
    logic [31:0] row3;
    logic        last;
  } col_t;

  // Next index modulo 3
  function automatic logic [1:0] nxt3(input logic [1:0] i);
    nxt3 = (i == 2'd2) ? 2'd0 : i + 2'd1;
  endfunction

  // Drop FRAC_BITS fraction bits, half away from zero, clamp to 32 bits
  function automatic logic signed [31:0] rnd_sat(input logic signed [63:0] x);
    logic [63:0]        m;
    logic [63:0]        q;
    logic signed [63:0] v;
    m = x[63] ? 64'(-x) : 64'(x);
    q = (m + (64'd1 << (FRAC_BITS - 1))) >> FRAC_BITS;
    v = x[63] ? -$signed(q) : $signed(q);
    if (v > 64'sh0000_0000_7FFF_FFFF) begin
      rnd_sat = 32'sh7FFF_FFFF;
    end else if (v < -64'sh0000_0000_8000_0000) begin
      rnd_sat = 32'sh8000_0000;
    end else begin
      rnd_sat = v[31:0];
    end
  endfunction

endpackage

>>> src/lookat_view_matrix_top.sv
// lookat_view_matrix_top: right-handed look-at view matrix in Q16.16, column-major.
// Instantiates lvm_front, lvm_fifo, lvm_back and lvm_out; uses lvm_pkg.
//
//   channel   dir   payload
//   s_axis    in    tdata: eye_x,eye_y,eye_z,target_x,target_y,target_z,up_x,up_y,up_z
//   m_axis    out   tdata: row0..row3; tuser: column; tlast: last
//
// Each request passes through the back sequencer, which ends by emitting the four
// columns. Its time is set by the 32-step square root and three
// (FRAC_BITS+2)-step divides of each of the two normalizations, plus the
// one-bit-per-cycle range shift. A zero view direction skips the roots and divides.
// The front and a two-entry queue take new requests while the back works.
// Synchronous active-high reset clears all handshake state.
module lookat_view_matrix_top (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [287:0] s_axis_tdata,   // eye_x, eye_y, eye_z, target_x..z, up_x..z (32 each)
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  output logic [127:0] m_axis_tdata,   // row0, row1, row2, row3 (32 each)
  output logic [1:0]   m_axis_tuser,   // column
  output logic         m_axis_tlast
);
  import lvm_pkg::*;

  logic  push;
  item_t push_item;
  logic  full;
  logic  pop;
  logic  pop_valid;
  item_t pop_item;
  logic  b_valid;
  logic  b_ready;
  col_t  b_col;
  col_t  m_col;

  lvm_front u_front (
    .clk       (clk),
    .rst       (rst),
    .s_valid   (s_axis_tvalid),
    .s_ready   (s_axis_tready),
    .s_data    (s_axis_tdata),
    .push      (push),
    .push_item (push_item),
    .full      (full)
  );

  lvm_fifo u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_item (push_item),
    .full      (full),
    .pop       (pop),
    .pop_valid (pop_valid),
    .pop_item  (pop_item)
  );

  lvm_back u_back (
    .clk     (clk),
    .rst     (rst),
    .q_valid (pop_valid),
    .q_item  (pop_item),
    .q_pop   (pop),
    .o_valid (b_valid),
    .o_ready (b_ready),
    .o_col   (b_col)
  );

  lvm_out u_out (
    .clk      (clk),
    .rst      (rst),
    .in_valid (b_valid),
    .in_ready (b_ready),
    .in_col   (b_col),
    .m_valid  (m_axis_tvalid),
    .m_ready  (m_axis_tready),
    .m_col    (m_col)
  );

  assign m_axis_tdata = {m_col.row3, m_col.row2, m_col.row1, m_col.row0};
  assign m_axis_tuser = m_col.column;
  assign m_axis_tlast = m_col.last;

endmodule

>>> src/lvm_front.sv
// lvm_front: accepts input requests, forms target minus eye, hands them to the queue.
// Depends on lvm_pkg.
module lvm_front (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_valid,
  output logic                  s_ready,
  input  logic [287:0]          s_data,
  output logic                  push,
  output lvm_pkg::item_t        push_item,
  input  logic                  full
);
  import lvm_pkg::*;

  logic  hold_valid;
  item_t hold;
  item_t in_item;

  // Unpack fields and form the exact 33-bit difference
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      in_item.eye[i] = s_data[32*i +: 32];
      in_item.up[i]  = s_data[192 + 32*i +: 32];
      in_item.d[i]   = 33'($signed(s_data[96 + 32*i +: 32])) -
                       33'($signed(s_data[32*i +: 32]));
    end
  end

  assign push      = hold_valid && !full;
  assign push_item = hold;
  assign s_ready   = !hold_valid || !full;

  // Holding stage
  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
    end else begin
      if (s_valid && s_ready) begin
        hold_valid <= 1'b1;
        hold       <= in_item;
      end else if (push) begin
        hold_valid <= 1'b0;
      end
    end
  end

endmodule

>>> src/lvm_fifo.sv
// lvm_fifo: two-entry request queue between front and back.
// Depends on lvm_pkg.
module lvm_fifo (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  lvm_pkg::item_t push_item,
  output logic           full,
  input  logic           pop,
  output logic           pop_valid,
  output lvm_pkg::item_t pop_item
);
  import lvm_pkg::*;

  item_t      mem [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;

  assign full      = (count == 2'd2);
  assign pop_valid = (count != 2'd0);
  assign pop_item  = mem[rd_ptr];

  // Pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= !wr_ptr;
      end
      if (pop) begin
        rd_ptr <= !rd_ptr;
      end
      if (push && !pop) begin
        count <= count + 2'd1;
      end else if (pop && !push) begin
        count <= count - 2'd1;
      end
    end
  end

  // Storage
  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_item;
    end
  end

endmodule

>>> src/lvm_back.sv
// lvm_back: sequencer that normalizes, forms cross and dot products and emits columns.
// One shared 32x32 multiplier, a bit-pair square root and a restoring divider. Uses lvm_pkg.
module lvm_back (
  input  logic           clk,
  input  logic           rst,
  input  logic           q_valid,
  input  lvm_pkg::item_t q_item,
  output logic           q_pop,
  output logic           o_valid,
  input  logic           o_ready,
  output lvm_pkg::col_t  o_col
);
  import lvm_pkg::*;

  localparam logic [3:0] S_IDLE     = 4'd0;
  localparam logic [3:0] S_N_ABS    = 4'd1;
  localparam logic [3:0] S_N_SHIFT  = 4'd2;
  localparam logic [3:0] S_MAC      = 4'd3;
  localparam logic [3:0] S_SQRT     = 4'd4;
  localparam logic [3:0] S_DIV_INIT = 4'd5;
  localparam logic [3:0] S_DIV      = 4'd6;
  localparam logic [3:0] S_N_END    = 4'd7;
  localparam logic [3:0] S_EMIT     = 4'd8;

  localparam logic [1:0] J_SQ  = 2'd0;
  localparam logic [1:0] J_C1  = 2'd1;
  localparam logic [1:0] J_C2  = 2'd2;
  localparam logic [1:0] J_DOT = 2'd3;

  logic [3:0]          state;
  logic                which;
  logic [1:0]          job;
  logic [1:0]          comp;
  logic [1:0]          k;
  logic [4:0]          cnt;
  logic [1:0]          dcomp;
  logic [1:0]          col;
  logic [JW-1:0]       j;

  logic signed [31:0]  eye [3];
  logic signed [31:0]  up [3];
  logic signed [63:0]  v [3];
  logic [63:0]         a [3];
  logic [2:0]          neg;
  logic signed [31:0]  f [3];
  logic signed [31:0]  s [3];
  logic signed [31:0]  u [3];
  logic signed [31:0]  t [3];
  logic signed [31:0]  nres [3];
  logic signed [63:0]  acc;
  logic signed [63:0]  prod;
  logic [63:0]         sq_n;
  logic [63:0]         sq_r;
  logic [63:0]         sq_b;
  logic [31:0]         len;
  logic [63:0]         dn;
  logic [31:0]         rem;
  logic [QW-1:0]       quo;

  // Combinational helpers
  logic [1:0]          i1;
  logic [1:0]          i2;
  logic [1:0]          kk;
  logic signed [31:0]  ma;
  logic signed [31:0]  mb;
  logic signed [63:0]  term;
  logic signed [63:0]  fin;
  logic                mac_last;
  logic [63:0]         m01;
  logic [63:0]         mx;
  logic [63:0]         rb;
  logic                sq_ge;
  logic [63:0]         r_nx;
  logic [32:0]         remsh;
  logic                dv_ge;
  logic [31:0]         rem_nx;
  logic [QW-1:0]       quo_nx;
  logic [31:0]         qf;
  logic [63:0]         nnum;

  // Operand select for the shared multiplier
  always_comb begin
    i1 = nxt3(comp);
    i2 = nxt3(i1);
    kk = (k == 2'd3) ? 2'd0 : k;
    ma = '0;
    mb = '0;
    case (job)
      J_SQ: begin
        ma = $signed(a[kk][31:0]);
        mb = $signed(a[kk][31:0]);
      end
      J_C1: begin
        ma = (k == 2'd0) ? f[i1] : f[i2];
        mb = (k == 2'd0) ? up[i2] : up[i1];
      end
      J_C2: begin
        ma = (k == 2'd0) ? s[i1] : s[i2];
        mb = (k == 2'd0) ? f[i2] : f[i1];
      end
      default: begin
        ma = (comp == 2'd0) ? s[kk] : ((comp == 2'd1) ? u[kk] : f[kk]);
        mb = eye[kk];
      end
    endcase
  end

  // Accumulate: second product of a cross term is subtracted
  always_comb begin
    mac_last = (job == J_C1 || job == J_C2) ? (k == 2'd2) : (k == 2'd3);
    term     = ((job == J_C1 || job == J_C2) && k == 2'd2) ? -prod : prod;
    fin      = acc + term;
  end

  // Largest magnitude
  always_comb begin
    m01 = (a[0] > a[1]) ? a[0] : a[1];
    mx  = (m01 > a[2]) ? m01 : a[2];
  end

  // Square root step
  always_comb begin
    rb    = sq_r + sq_b;
    sq_ge = (sq_n >= rb);
    r_nx  = sq_ge ? ((sq_r >> 1) + sq_b) : (sq_r >> 1);
  end

  // Divide step and setup
  always_comb begin
    remsh  = {rem, dn[j]};
    dv_ge  = (remsh >= {1'b0, len});
    rem_nx = dv_ge ? 32'(remsh - {1'b0, len}) : remsh[31:0];
    quo_nx = {quo[QW-2:0], dv_ge};
    qf     = 32'(quo_nx);
    nnum   = (a[dcomp] << FRAC_BITS) + 64'(len >> 1);
  end

  assign q_pop   = (state == S_IDLE) && q_valid;
  assign o_valid = (state == S_EMIT);

  // Column being offered
  always_comb begin
    o_col.column = col;
    if (col == 2'd3) begin
      o_col.row0 = t[0];
      o_col.row1 = t[1];
      o_col.row2 = t[2];
      o_col.row3 = ONE_FIX;
      o_col.last = 1'b1;
    end else begin
      o_col.row0 = s[col];
      o_col.row1 = u[col];
      o_col.row2 = -f[col];
      o_col.row3 = '0;
      o_col.last = 1'b0;
    end
  end

  // Multiplier output register
  always_ff @(posedge clk) begin
    prod <= 64'(ma) * 64'(mb);
  end

  // Sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (q_valid) begin
            for (int i = 0; i < 3; i++) begin
              eye[i] <= $signed(q_item.eye[i]);
              up[i]  <= $signed(q_item.up[i]);
              v[i]   <= 64'($signed(q_item.d[i]));
            end
            which <= 1'b0;
            state <= S_N_ABS;
          end
        end
        S_N_ABS: begin
          for (int i = 0; i < 3; i++) begin
            a[i]   <= v[i][63] ? 64'(-v[i]) : 64'(v[i]);
            neg[i] <= v[i][63];
          end
          state <= S_N_SHIFT;
        end
        S_N_SHIFT: begin
          if (mx == 64'd0) begin
            for (int i = 0; i < 3; i++) begin
              nres[i] <= '0;
            end
            state <= S_N_END;
          end else if (mx >= (64'd1 << 30)) begin
            for (int i = 0; i < 3; i++) begin
              a[i] <= a[i] >> 1;
            end
          end else if (mx < (64'd1 << 29)) begin
            for (int i = 0; i < 3; i++) begin
              a[i] <= a[i] << 1;
            end
          end else begin
            job   <= J_SQ;
            k     <= 2'd0;
            state <= S_MAC;
          end
        end
        S_MAC: begin
          if (k == 2'd0) begin
            acc <= '0;
            k   <= 2'd1;
          end else if (!mac_last) begin
            acc <= fin;
            k   <= k + 2'd1;
          end else begin
            k <= 2'd0;
            case (job)
              J_SQ: begin
                sq_n  <= 64'(fin);
                sq_r  <= '0;
                sq_b  <= 64'd1 << 62;
                cnt   <= '0;
                state <= S_SQRT;
              end
              J_C1: begin
                v[comp] <= fin;
                if (comp == 2'd2) begin
                  which <= 1'b1;
                  state <= S_N_ABS;
                end else begin
                  comp <= comp + 2'd1;
                end
              end
              J_C2: begin
                u[comp] <= rnd_sat(fin);
                if (comp == 2'd2) begin
                  job  <= J_DOT;
                  comp <= 2'd0;
                end else begin
                  comp <= comp + 2'd1;
                end
              end
              default: begin
                t[comp] <= rnd_sat((comp == 2'd2) ? fin : -fin);
                if (comp == 2'd2) begin
                  col   <= 2'd0;
                  state <= S_EMIT;
                end else begin
                  comp <= comp + 2'd1;
                end
              end
            endcase
          end
        end
        S_SQRT: begin
          if (sq_ge) begin
            sq_n <= sq_n - rb;
          end
          sq_r <= r_nx;
          sq_b <= sq_b >> 2;
          cnt  <= cnt + 5'd1;
          if (cnt == 5'd31) begin
            len   <= r_nx[31:0];
            dcomp <= 2'd0;
            state <= S_DIV_INIT;
          end
        end
        S_DIV_INIT: begin
          dn    <= nnum;
          rem   <= 32'(nnum >> QW);
          quo   <= '0;
          j     <= JW'(QW - 1);
          state <= S_DIV;
        end
        S_DIV: begin
          rem <= rem_nx;
          quo <= quo_nx;
          j   <= j - 1'b1;
          if (j == '0) begin
            nres[dcomp] <= neg[dcomp] ? -$signed(qf) : $signed(qf);
            if (dcomp == 2'd2) begin
              state <= S_N_END;
            end else begin
              dcomp <= dcomp + 2'd1;
              state <= S_DIV_INIT;
            end
          end
        end
        S_N_END: begin
          if (!which) begin
            for (int i = 0; i < 3; i++) begin
              f[i] <= nres[i];
            end
            job <= J_C1;
          end else begin
            for (int i = 0; i < 3; i++) begin
              s[i] <= nres[i];
            end
            job <= J_C2;
          end
          comp  <= 2'd0;
          k     <= 2'd0;
          state <= S_MAC;
        end
        S_EMIT: begin
          if (o_ready) begin
            col <= col + 2'd1;
            if (col == 2'd3) begin
              state <= S_IDLE;
            end
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

>>> src/lvm_out.sv
// lvm_out: output register between the sequencer and the result stream.
// Depends on lvm_pkg.
module lvm_out (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_ready,
  input  lvm_pkg::col_t in_col,
  output logic          m_valid,
  input  logic          m_ready,
  output lvm_pkg::col_t m_col
);
  import lvm_pkg::*;

  assign in_ready = !m_valid || m_ready;

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        m_valid <= 1'b1;
        m_col   <= in_col;
      end else if (m_ready) begin
        m_valid <= 1'b0;
      end
    end
  end

endmodule
